[hdl/pli_pkg.sv]
`timescale 1ns / 1ps

package pli_pkg;

	// field widths
	localparam int LVL_W  = 32;
	localparam int FAC_W  = 16;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;
	localparam int STAT_W = 2;
	localparam int PROD_W = LVL_W + FAC_W;

	// default table capacity and queue depths
	localparam int MAX_POINTS_DEF = 16;
	localparam int CMD_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;

	// request operation codes
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOSEG = 2'd2;

	// request as seen on the input port
	typedef struct packed {
		logic                    operation;
		logic [IDX_W-1:0]        point_index;
		logic signed [LVL_W-1:0] point_level;
		logic [FAC_W-1:0]        point_factor;
		logic signed [LVL_W-1:0] query_level;
	} req_t;

	// result as seen on the output port
	typedef struct packed {
		logic [FAC_W-1:0]  factor;
		logic [STAT_W-1:0] status;
	} res_t;

	// command class decided by the front end
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_ZERO  = 2'd2,
		CMD_EMPTY = 2'd3
	} cmd_kind_t;

	// command passed from front end to back end
	typedef struct packed {
		cmd_kind_t               kind;
		logic [IDX_W-1:0]        index;
		logic signed [LVL_W-1:0] level;
		logic [FAC_W-1:0]        factor;
	} cmd_t;

endpackage

[hdl/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  request   in         push / full        pli_pkg::req_t (operation, point, query level)
//  result    out        pop / empty        pli_pkg::res_t (factor, status)
//  config    in         cfg_wen            cfg_wdata = point_count
//
//  A breakpoint write is stored as soon as the back end takes it. A query runs a
//  sweep of the breakpoint memory, one entry per cycle through its single read
//  port, then, for a level inside a segment, a bit-serial divider.
//  Queries at or below zero or on an empty table skip the sweep and the divider.
//  Reset clears the queues, the sequencer and point_count; the table is not cleared.
//  Two-entry queues sit at the input and output, so either side may stall freely.

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  pli_pkg::req_t               request,
	output logic                        empty,
	input  logic                        pop,
	output pli_pkg::res_t               result,
	input  logic                        cfg_wen,
	input  logic [pli_pkg::CNT_W-1:0]   cfg_wdata
);

	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [pli_pkg::CNT_W-1:0] point_count_q;
	logic [31:0]               n_wide;
	logic [CW-1:0]             n_used;
	pli_pkg::cmd_t             cmd;
	logic                      cmd_empty;
	logic                      cmd_pop;
	logic                      res_full;
	logic                      res_push;
	pli_pkg::res_t             res;

	// point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_wen) begin
			point_count_q <= cfg_wdata;
		end
	end

	// entries in use, clamped to capacity
	assign n_wide = (32'(point_count_q) > 32'(MAX_POINTS)) ?
		32'(MAX_POINTS) : 32'(point_count_q);
	assign n_used = n_wide[CW-1:0];

	pli_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.n_used   (n_used),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	pli_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.n_used   (n_used),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue
	pli_fifo #(
		.T     (pli_pkg::res_t),
		.DEPTH (pli_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

[hdl/pli_fifo.sv]
`timescale 1ns / 1ps

module pli_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hdl/pli_front.sv]
`timescale 1ns / 1ps

module pli_front #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  pli_pkg::req_t                      request,
	input  logic [$clog2(MAX_POINTS+1)-1:0]    n_used,
	input  logic                               cmd_pop,
	output logic                               cmd_empty,
	output pli_pkg::cmd_t                      cmd
);

	pli_pkg::cmd_t cls;
	logic          drop;
	logic          cmd_full;

	// classify the incoming request
	always_comb begin
		cls.index  = request.point_index;
		cls.factor = request.point_factor;
		drop       = 1'b0;
		if (request.operation == pli_pkg::OP_WRITE) begin
			cls.kind  = pli_pkg::CMD_WRITE;
			cls.level = request.point_level;
			drop      = (32'(request.point_index) >= 32'(MAX_POINTS));
		end else begin
			cls.level = request.query_level;
			if ($signed(request.query_level) <= 0) begin
				cls.kind = pli_pkg::CMD_ZERO;
			end else if (n_used == '0) begin
				cls.kind = pli_pkg::CMD_EMPTY;
			end else begin
				cls.kind = pli_pkg::CMD_QUERY;
			end
		end
	end

	assign full = cmd_full;

	// command queue toward the back end
	pli_fifo #(
		.T     (pli_pkg::cmd_t),
		.DEPTH (pli_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !drop),
		.wdata (cls),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

[hdl/pli_div.sv]
`timescale 1ns / 1ps

module pli_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pli_pkg::PROD_W-1:0]  dividend,
	input  logic [pli_pkg::LVL_W-1:0]   divisor,
	output logic                        done,
	output logic [pli_pkg::FAC_W-1:0]   quotient
);

	localparam int QW = pli_pkg::FAC_W;
	localparam int RW = pli_pkg::LVL_W;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW:0]   trial;
	logic [RW:0]   trial_sub;
	logic          take;

	// one restoring step per cycle, quotient known to fit in QW bits
	assign trial     = {rem_q, quo_q[QW-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign take      = (trial >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = quo_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(QW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[pli_pkg::PROD_W-1:QW];
			quo_q <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= take ? trial_sub[RW-1:0] : trial[RW-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

endmodule

[hdl/pli_back.sv]
`timescale 1ns / 1ps

module pli_back #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pli_pkg::cmd_t                      cmd,
	input  logic                               cmd_empty,
	output logic                               cmd_pop,
	input  logic [$clog2(MAX_POINTS+1)-1:0]    n_used,
	input  logic                               res_full,
	output logic                               res_push,
	output pli_pkg::res_t                      res
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = pli_pkg::LVL_W;
	localparam int FW = pli_pkg::FAC_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FIRST = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [LW-1:0]        lvl_mem_q [MAX_POINTS];
	logic [FW-1:0]        fac_mem_q [MAX_POINTS];
	logic [LW-1:0]        rd_lvl_q;
	logic [FW-1:0]        rd_fac_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        last_idx;
	logic                 take_cmd;
	logic                 mem_we;

	logic [LW-1:0]        level_q;
	logic [LW-1:0]        last_lvl_q;
	logic [FW-1:0]        last_fac_q;
	logic [LW-1:0]        prev_lvl_q;
	logic [FW-1:0]        prev_fac_q;
	logic [CW-1:0]        ptr_q;
	logic [AW-1:0]        chk_q;
	logic [LW-1:0]        step_q;
	logic [LW-1:0]        span_q;
	logic [FW-1:0]        mag_q;
	logic [FW-1:0]        fhi_q;
	logic                 neg_q;
	pli_pkg::res_t        res_q;

	logic                 first_chk;
	logic                 le_cur;
	logic                 ge_last;
	logic                 gt_prev;
	logic                 at_end;
	logic                 hit_first;
	logic                 hit_last;
	logic                 hit_seg;
	logic                 miss;
	logic [LW:0]          step_w;
	logic [LW:0]          span_w;
	logic                 neg_w;
	logic [FW-1:0]        mag_w;
	logic [pli_pkg::PROD_W-1:0] prod_w;
	logic                 div_done;
	logic [FW-1:0]        div_quo;

	assign take_cmd = (state_q == ST_IDLE) && !cmd_empty;
	assign cmd_pop  = take_cmd;
	assign mem_we   = take_cmd && (cmd.kind == pli_pkg::CMD_WRITE);
	assign last_idx = AW'(n_used - CW'(1));

	// read address: last entry first, then a forward sweep from entry 0
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = last_idx;
			ST_FIRST: rd_addr = '0;
			ST_SCAN:  rd_addr = AW'(ptr_q);
			default:  rd_addr = '0;
		endcase
	end

	// breakpoint memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			lvl_mem_q[AW'(cmd.index)] <= cmd.level;
			fac_mem_q[AW'(cmd.index)] <= cmd.factor;
		end
		rd_lvl_q <= lvl_mem_q[rd_addr];
		rd_fac_q <= fac_mem_q[rd_addr];
	end

	// segment search on the entry just read
	assign first_chk = (chk_q == '0);
	assign at_end    = (chk_q == last_idx);
	assign le_cur    = ($signed(level_q) <= $signed(rd_lvl_q));
	assign ge_last   = ($signed(level_q) >= $signed(last_lvl_q));
	assign gt_prev   = ($signed(level_q) > $signed(prev_lvl_q));
	assign hit_first = first_chk && le_cur;
	assign hit_last  = first_chk && !le_cur && ge_last;
	assign hit_seg   = !first_chk && gt_prev && le_cur;
	assign miss      = !first_chk && !hit_seg && at_end;

	// segment step, distance to the upper end and factor difference
	assign step_w = {rd_lvl_q[LW-1], rd_lvl_q} - {prev_lvl_q[LW-1], prev_lvl_q};
	assign span_w = {rd_lvl_q[LW-1], rd_lvl_q} - {level_q[LW-1], level_q};
	assign neg_w  = (prev_fac_q < rd_fac_q);
	assign mag_w  = neg_w ? (rd_fac_q - prev_fac_q) : (prev_fac_q - rd_fac_q);

	// scaled difference, registered at the divider input
	assign prod_w = pli_pkg::PROD_W'(mag_q) * pli_pkg::PROD_W'(span_q);

	pli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_MUL),
		.dividend(prod_w),
		.divisor (step_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			chk_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take_cmd) begin
						case (cmd.kind)
							pli_pkg::CMD_WRITE: state_q <= ST_IDLE;
							pli_pkg::CMD_QUERY: state_q <= ST_FIRST;
							default:            state_q <= ST_EMIT;
						endcase
					end
				end
				ST_FIRST: begin
					ptr_q   <= CW'(1);
					chk_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					chk_q <= chk_q + 1'b1;
					if (hit_first || hit_last || miss) begin
						state_q <= ST_EMIT;
					end else if (hit_seg) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_cmd) begin
					level_q      <= cmd.level;
					res_q.factor <= '0;
					res_q.status <= (cmd.kind == pli_pkg::CMD_EMPTY) ?
						pli_pkg::STAT_EMPTY : pli_pkg::STAT_OK;
				end
			end
			ST_FIRST: begin
				last_lvl_q <= rd_lvl_q;
				last_fac_q <= rd_fac_q;
			end
			ST_SCAN: begin
				prev_lvl_q <= rd_lvl_q;
				prev_fac_q <= rd_fac_q;
				if (hit_first) begin
					res_q.factor <= rd_fac_q;
					res_q.status <= pli_pkg::STAT_OK;
				end else if (hit_last) begin
					res_q.factor <= last_fac_q;
					res_q.status <= pli_pkg::STAT_OK;
				end else if (hit_seg) begin
					step_q <= step_w[LW-1:0];
					span_q <= span_w[LW-1:0];
					mag_q  <= mag_w;
					neg_q  <= neg_w;
					fhi_q  <= rd_fac_q;
				end else if (miss) begin
					res_q.factor <= '0;
					res_q.status <= pli_pkg::STAT_NOSEG;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_q.factor <= neg_q ? (fhi_q - div_quo) : (fhi_q + div_quo);
					res_q.status <= pli_pkg::STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_push = (state_q == ST_EMIT) && !res_full;
	assign res      = res_q;

endmodule

[hdl/pli_checker.sv]
`timescale 1ns / 1ps

module pli_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input pli_pkg::req_t request,
	input logic          empty,
	input logic          pop,
	input pli_pkg::res_t result
);

	logic [3:0] pending_q;
	logic       query_acc;
	logic       result_acc;

	assign query_acc  = push && !full && (request.operation == pli_pkg::OP_QUERY);
	assign result_acc = pop && !empty;

	// queries accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (query_acc && !result_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (result_acc && !query_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// no result without an open query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == '0) |-> empty)
		else $error("result shown with no open query");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before pop");

	// status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == pli_pkg::STAT_OK ||
			result.status == pli_pkg::STAT_EMPTY ||
			result.status == pli_pkg::STAT_NOSEG))
		else $error("undefined status code");

	// error results carry a zero factor
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != pli_pkg::STAT_OK) |-> (result.factor == '0))
		else $error("error result with nonzero factor");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.request(request),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
